### hw/rtl/cmf_pkg.sv
// cube map face selection: shared constants, codes and types
// no dependencies
`default_nettype none
package cmf_pkg;
	localparam int COORD_BITS_DEF = 16;
	localparam int TEXEL_BITS_DEF = 13;
	localparam int OUT_DEPTH      = 32;
	localparam int CFG_IDX_BITS   = 2;
	localparam int SIZE_RESET     = 512;

	localparam logic [CFG_IDX_BITS-1:0] CFG_FACE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FACE_HEIGHT = 2'd1;

	localparam logic [2:0] FACE_POS_X = 3'd0;
	localparam logic [2:0] FACE_NEG_X = 3'd1;
	localparam logic [2:0] FACE_POS_Y = 3'd2;
	localparam logic [2:0] FACE_NEG_Y = 3'd3;
	localparam logic [2:0] FACE_POS_Z = 3'd4;
	localparam logic [2:0] FACE_NEG_Z = 3'd5;

	typedef struct packed {
		logic [2:0] face;
		logic       bad;
	} face_info_t;
endpackage
`default_nettype wire

### hw/rtl/cmf_front.sv
// front end: major axis pick, face code, offset minor components
// depends on cmf_pkg
`default_nettype none
module cmf_front #(
	parameter int COORD_BITS = cmf_pkg::COORD_BITS_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        push,
	output logic                       full,
	input  wire signed [COORD_BITS-1:0] dir_x,
	input  wire signed [COORD_BITS-1:0] dir_y,
	input  wire signed [COORD_BITS-1:0] dir_z,
	output logic                       out_valid,
	input  wire                        out_ready,
	output cmf_pkg::face_info_t        out_info,
	output logic [COORD_BITS:0]        out_na,
	output logic [COORD_BITS:0]        out_nb,
	output logic [COORD_BITS:0]        out_d
);
	logic [COORD_BITS-1:0] ax, ay, az, m;
	logic signed [COORD_BITS-1:0] a, b;
	cmf_pkg::face_info_t info;
	logic valid_q, load;
	cmf_pkg::face_info_t info_q;
	logic [COORD_BITS:0] na_q, nb_q, d_q;

	always_comb begin
		ax = dir_x[COORD_BITS-1] ? (~dir_x + 1'b1) : dir_x;
		ay = dir_y[COORD_BITS-1] ? (~dir_y + 1'b1) : dir_y;
		az = dir_z[COORD_BITS-1] ? (~dir_z + 1'b1) : dir_z;
		m = ax;
		if (ay > m) begin
			m = ay;
		end
		if (az > m) begin
			m = az;
		end
		info.bad = (m == '0);
		if (ax == m) begin
			info.face = dir_x[COORD_BITS-1] ? cmf_pkg::FACE_NEG_X : cmf_pkg::FACE_POS_X;
			a = dir_z;
			b = dir_y;
		end else if (ay == m) begin
			info.face = dir_y[COORD_BITS-1] ? cmf_pkg::FACE_NEG_Y : cmf_pkg::FACE_POS_Y;
			a = dir_x;
			b = dir_z;
		end else begin
			info.face = dir_z[COORD_BITS-1] ? cmf_pkg::FACE_NEG_Z : cmf_pkg::FACE_POS_Z;
			a = dir_x;
			b = dir_y;
		end
		if (info.bad) begin
			info.face = cmf_pkg::FACE_POS_X;
		end
	end

	assign full = valid_q && !out_ready;
	assign load = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= load || (valid_q && !out_ready);
		end
	end

	// a + m lies in 0..2m, so the wrapped sum is exact
	always_ff @(posedge clk) begin
		if (load) begin
			info_q <= info;
			na_q   <= {a[COORD_BITS-1], a} + {1'b0, m};
			nb_q   <= {b[COORD_BITS-1], b} + {1'b0, m};
			d_q    <= {m, 1'b0};
		end
	end

	assign out_valid = valid_q;
	assign out_info  = info_q;
	assign out_na    = na_q;
	assign out_nb    = nb_q;
	assign out_d     = d_q;
endmodule
`default_nettype wire

### hw/rtl/cmf_queue.sv
// two-entry queue between front and back
// depends on nothing outside itself
`default_nettype none
module cmf_queue #(
	parameter int WIDTH = 8
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             in_valid,
	output logic            in_ready,
	input  wire [WIDTH-1:0] in_data,
	output logic            out_valid,
	input  wire             out_ready,
	output logic [WIDTH-1:0] out_data
);
	logic [WIDTH-1:0] mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = mem_q[rp_q];
	assign wr = in_valid && in_ready;
	assign rd = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) begin
				wp_q <= ~wp_q;
			end
			if (rd) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= in_data;
		end
	end
endmodule
`default_nettype wire

### hw/rtl/cmf_back.sv
// back end: scale by face size, pipelined restoring divide, result queue
// depends on cmf_pkg
`default_nettype none
module cmf_back #(
	parameter int COORD_BITS = cmf_pkg::COORD_BITS_DEF,
	parameter int TEXEL_BITS = cmf_pkg::TEXEL_BITS_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  cmf_pkg::face_info_t   in_info,
	input  wire [COORD_BITS:0]    in_na,
	input  wire [COORD_BITS:0]    in_nb,
	input  wire [COORD_BITS:0]    in_d,
	input  wire [TEXEL_BITS-1:0]  face_width,
	input  wire [TEXEL_BITS-1:0]  face_height,
	output logic                  empty,
	input  wire                   pop,
	output logic [2:0]            face,
	output logic [TEXEL_BITS-1:0] texel_u,
	output logic [TEXEL_BITS-1:0] texel_v,
	output logic                  bad_direction
);
	localparam int PW    = COORD_BITS + 1 + TEXEL_BITS;
	localparam int DEPTH = cmf_pkg::OUT_DEPTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int EW    = 4 + 2 * TEXEL_BITS;

	logic issue;
	logic [CW-1:0] inflight_q;
	logic out_pop;

	// credit: every issued item has a reserved slot in the result queue
	assign in_ready = (inflight_q < CW'(DEPTH));
	assign issue    = in_valid && in_ready;

	// divider stage k resolves quotient bit TEXEL_BITS-1-k
	logic                 v_s [TEXEL_BITS+1];
	cmf_pkg::face_info_t  info_s [TEXEL_BITS+1];
	logic [COORD_BITS:0]  d_s [TEXEL_BITS+1];
	logic [PW-1:0]        ru_s [TEXEL_BITS+1];
	logic [PW-1:0]        rv_s [TEXEL_BITS+1];
	logic [TEXEL_BITS-1:0] qu_s [TEXEL_BITS+1];
	logic [TEXEL_BITS-1:0] qv_s [TEXEL_BITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= issue;
		end
	end

	always_ff @(posedge clk) begin
		info_s[0] <= in_info;
		d_s[0]    <= in_d;
		ru_s[0]   <= PW'(in_na) * PW'(face_width);
		rv_s[0]   <= PW'(in_nb) * PW'(face_height);
		qu_s[0]   <= '0;
		qv_s[0]   <= '0;
	end

	for (genvar k = 0; k < TEXEL_BITS; k++) begin : g_div
		localparam int SH = TEXEL_BITS - 1 - k;
		logic [PW-1:0] trial;
		logic take_u, take_v;

		assign trial  = {{TEXEL_BITS{1'b0}}, d_s[k]} << SH;
		assign take_u = (ru_s[k] >= trial);
		assign take_v = (rv_s[k] >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			info_s[k+1] <= info_s[k];
			d_s[k+1]    <= d_s[k];
			ru_s[k+1]   <= take_u ? (ru_s[k] - trial) : ru_s[k];
			rv_s[k+1]   <= take_v ? (rv_s[k] - trial) : rv_s[k];
			qu_s[k+1]   <= qu_s[k] | (TEXEL_BITS'(take_u) << SH);
			qv_s[k+1]   <= qv_s[k] | (TEXEL_BITS'(take_v) << SH);
		end
	end

	// result queue
	logic [EW-1:0] mem_q [DEPTH];
	logic [AW:0] wp_q, rp_q;
	logic [EW-1:0] wdata, rdata;
	logic wr;
	cmf_pkg::face_info_t fin;

	assign fin   = info_s[TEXEL_BITS];
	assign wr    = v_s[TEXEL_BITS];
	assign wdata = fin.bad ? {fin, {(2*TEXEL_BITS){1'b0}}}
	                       : {fin, qu_s[TEXEL_BITS], qv_s[TEXEL_BITS]};

	assign empty   = (wp_q == rp_q);
	assign out_pop = pop && !empty;
	assign rdata   = mem_q[rp_q[AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q       <= '0;
			rp_q       <= '0;
			inflight_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (out_pop) begin
				rp_q <= rp_q + 1'b1;
			end
			inflight_q <= inflight_q + CW'(issue) - CW'(out_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q[AW-1:0]] <= wdata;
		end
	end

	assign face          = rdata[EW-1 -: 3];
	assign bad_direction = rdata[2*TEXEL_BITS];
	assign texel_u       = rdata[2*TEXEL_BITS-1 -: TEXEL_BITS];
	assign texel_v       = rdata[TEXEL_BITS-1:0];
endmodule
`default_nettype wire

### hw/rtl/cube_map_face_and_texel_coords_core.sv
// cube map face selection and texel addressing, top level
// depends on cmf_pkg, cmf_front, cmf_queue, cmf_back
//
// usage
//  - input side is a queue: drive dir_x/y/z with push; a request is taken
//    at a clock edge with push high and full low
//  - result side is a queue: while empty is low the oldest result sits on
//    face, texel_u, texel_v, bad_direction; pop takes it
//  - config: cfg_valid with cfg_index (0 face_width, 1 face_height) and
//    cfg_data; cfg_ready is always high, other indexes are ignored
//  - one request per cycle sustained while full stays low; after the
//    accepting edge loads the front register, a request passes the middle
//    queue, where the back end may hold it, the multiply stage, one divider
//    stage per quotient bit and the result queue write, then empty falls
//  - rate is set by the pipelined divider, one quotient bit per stage for
//    u and v in parallel, after a single multiply stage
//  - when pop stalls, the result queue (32 entries) fills; the back end
//    stops taking from the middle queue once all slots are reserved, then
//    the front holds and full rises; nothing is dropped
//  - reset clears all queues and sets both face sizes to 512
`default_nettype none
module cube_map_face_and_texel_coords_core #(
	parameter int COORD_BITS = cmf_pkg::COORD_BITS_DEF,
	parameter int TEXEL_BITS = cmf_pkg::TEXEL_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          push,
	output logic                         full,
	input  wire signed [COORD_BITS-1:0]  dir_x,
	input  wire signed [COORD_BITS-1:0]  dir_y,
	input  wire signed [COORD_BITS-1:0]  dir_z,
	output logic                         empty,
	input  wire                          pop,
	output logic [2:0]                   face,
	output logic [TEXEL_BITS-1:0]        texel_u,
	output logic [TEXEL_BITS-1:0]        texel_v,
	output logic                         bad_direction,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire [cmf_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  wire [TEXEL_BITS-1:0]         cfg_data
);
	localparam int QW = 4 + 3 * (COORD_BITS + 1);

	// face size registers
	logic [TEXEL_BITS-1:0] face_width_q, face_height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_width_q  <= TEXEL_BITS'(cmf_pkg::SIZE_RESET);
			face_height_q <= TEXEL_BITS'(cmf_pkg::SIZE_RESET);
		end else if (cfg_valid) begin
			case (cfg_index)
				cmf_pkg::CFG_FACE_WIDTH: begin
					face_width_q <= cfg_data;
				end
				cmf_pkg::CFG_FACE_HEIGHT: begin
					face_height_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// front: classify
	logic                f_valid, f_ready;
	cmf_pkg::face_info_t f_info;
	logic [COORD_BITS:0] f_na, f_nb, f_d;

	cmf_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.dir_x     (dir_x),
		.dir_y     (dir_y),
		.dir_z     (dir_z),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_info  (f_info),
		.out_na    (f_na),
		.out_nb    (f_nb),
		.out_d     (f_d)
	);

	// middle queue decouples front and back
	logic          q_valid, q_ready;
	logic [QW-1:0] q_data;
	cmf_pkg::face_info_t q_info;
	logic [COORD_BITS:0] q_na, q_nb, q_d;

	cmf_queue #(.WIDTH(QW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   ({f_info, f_na, f_nb, f_d}),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_data  (q_data)
	);

	assign {q_info, q_na, q_nb, q_d} = q_data;

	// back: scale, divide, hold results
	cmf_back #(
		.COORD_BITS (COORD_BITS),
		.TEXEL_BITS (TEXEL_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (q_valid),
		.in_ready      (q_ready),
		.in_info       (q_info),
		.in_na         (q_na),
		.in_nb         (q_nb),
		.in_d          (q_d),
		.face_width    (face_width_q),
		.face_height   (face_height_q),
		.empty         (empty),
		.pop           (pop),
		.face          (face),
		.texel_u       (texel_u),
		.texel_v       (texel_v),
		.bad_direction (bad_direction)
	);
endmodule
`default_nettype wire
